[rtl/dfpb_pkg.sv]
package dfpb_pkg;

	localparam int DEPTH_DEF     = 16;
	localparam int ADDR_BITS_DEF = 16;

	localparam int ACT_W   = 2;
	localparam int ADDR_W  = 16;
	localparam int STAMP_W = 32;
	localparam int LIMIT_W = 5;
	localparam int CNT_W   = 5;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;
	localparam logic [CNT_W-1:0]   CNT_MAX     = 5'd31;

	localparam logic [ACT_W-1:0] ACT_ADD = 2'd0;
	localparam logic [ACT_W-1:0] ACT_FWD = 2'd1;
	localparam logic [ACT_W-1:0] ACT_CNT = 2'd2;

endpackage

[rtl/dedup_fifo_packet_buffer.sv]
// Channel   Signals                                   Transfer
// command   start busy action src_addr dst_addr       start && !busy
//           stamp window_start window_end
// result    done ok out_src out_dst out_stamp         done (one cycle)
//           match_count
// config    cfg_valid cfg_ready cfg_data              cfg_valid && cfg_ready
//
// Transfer to result: one stored entry is read per cycle from the slot memory and
// checked by the duplicate and count comparators, then pointer update and, for an
// add, write-back.
// Reset clears pointers and fill level and sets the limit to 16; slot memory is not cleared.
// The result strobe cannot be stalled; busy drops in the cycle the result shows.
module dedup_fifo_packet_buffer #(
	parameter int DEPTH     = dfpb_pkg::DEPTH_DEF,
	parameter int ADDR_BITS = dfpb_pkg::ADDR_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [dfpb_pkg::ACT_W-1:0]    action,
	input  logic [dfpb_pkg::ADDR_W-1:0]   src_addr,
	input  logic [dfpb_pkg::ADDR_W-1:0]   dst_addr,
	input  logic [dfpb_pkg::STAMP_W-1:0]  stamp,
	input  logic [dfpb_pkg::STAMP_W-1:0]  window_start,
	input  logic [dfpb_pkg::STAMP_W-1:0]  window_end,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [dfpb_pkg::LIMIT_W-1:0]  cfg_data,
	output logic                          done,
	output logic                          ok,
	output logic [dfpb_pkg::ADDR_W-1:0]   out_src,
	output logic [dfpb_pkg::ADDR_W-1:0]   out_dst,
	output logic [dfpb_pkg::STAMP_W-1:0]  out_stamp,
	output logic [dfpb_pkg::CNT_W-1:0]    match_count
);
	import dfpb_pkg::*;

	localparam int AW = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
	localparam int WW = 2 * AW + STAMP_W;
	localparam int HW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FW = $clog2(DEPTH + 1);
	localparam int SW = FW + 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_ADJ  = 2'd2;
	localparam logic [1:0] ST_WR   = 2'd3;

	logic [1:0]         state_q;
	logic [HW-1:0]      head_q;
	logic [FW-1:0]      fill_q;
	logic [FW-1:0]      k_q;
	logic [FW-1:0]      len_q;
	logic               rd_vld_s1;
	logic               dup_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [LIMIT_W-1:0] limit_q;
	logic               done_q;

	logic [ACT_W-1:0]   act_q;
	logic [AW-1:0]      src_q;
	logic [AW-1:0]      dst_q;
	logic [STAMP_W-1:0] stamp_q;
	logic [STAMP_W-1:0] ws_q;
	logic [STAMP_W-1:0] we_q;

	logic               ok_q;
	logic [ADDR_W-1:0]  out_src_q;
	logic [ADDR_W-1:0]  out_dst_q;
	logic [STAMP_W-1:0] out_stamp_q;
	logic [CNT_W-1:0]   match_q;

	logic               accept;
	logic               issue;
	logic [FW-1:0]      lim_eff;
	logic [SW-1:0]      rd_sum;
	logic [SW-1:0]      rd_wrap;
	logic [HW-1:0]      rd_idx;
	logic [SW-1:0]      wr_sum;
	logic [SW-1:0]      wr_wrap;
	logic [HW-1:0]      wr_idx;
	logic [FW-1:0]      new_fill;
	logic [SW-1:0]      adv_sum;
	logic [SW-1:0]      adv_wrap;
	logic [SW-1:0]      adv;
	logic               mem_we;
	logic [WW-1:0]      rdata;
	logic [AW-1:0]      rd_src;
	logic [AW-1:0]      rd_dst;
	logic [STAMP_W-1:0] rd_stamp;
	logic               hit_dup;
	logic               hit_cnt;

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign issue     = (state_q == ST_SCAN) && (k_q != len_q);
	assign mem_we    = (state_q == ST_WR);

	always_comb begin
		if (limit_q == '0) begin
			lim_eff = FW'(1);
		end else if (32'(limit_q) > DEPTH) begin
			lim_eff = FW'(DEPTH);
		end else begin
			lim_eff = FW'(limit_q);
		end
	end

	assign rd_sum  = SW'(head_q) + SW'(k_q);
	assign rd_wrap = (rd_sum >= SW'(DEPTH)) ? rd_sum - SW'(DEPTH) : rd_sum;
	assign rd_idx  = HW'(rd_wrap);

	assign wr_sum  = SW'(head_q) + SW'(fill_q);
	assign wr_wrap = (wr_sum >= SW'(DEPTH)) ? wr_sum - SW'(DEPTH) : wr_sum;
	assign wr_idx  = HW'(wr_wrap);

	// add makes room under the limit, forward drops one
	always_comb begin
		new_fill = fill_q;
		if ((act_q == ACT_ADD) && (fill_q >= lim_eff)) begin
			new_fill = lim_eff - FW'(1);
		end else if ((act_q == ACT_FWD) && (fill_q != '0)) begin
			new_fill = fill_q - FW'(1);
		end
	end

	assign adv      = SW'(fill_q) - SW'(new_fill);
	assign adv_sum  = SW'(head_q) + adv;
	assign adv_wrap = (adv_sum >= SW'(DEPTH)) ? adv_sum - SW'(DEPTH) : adv_sum;

	assign rd_src   = rdata[WW-1 -: AW];
	assign rd_dst   = rdata[STAMP_W +: AW];
	assign rd_stamp = rdata[STAMP_W-1:0];

	assign hit_dup = (rd_src == src_q) && (rd_dst == dst_q) && (rd_stamp == stamp_q);
	assign hit_cnt = (rd_dst == dst_q) && (rd_stamp >= ws_q) && (rd_stamp <= we_q);

	dfpb_mem #(
		.WIDTH (WW),
		.DEPTH (DEPTH),
		.IDX_W (HW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (wr_idx),
		.wdata ({src_q, dst_q, stamp_q}),
		.re    (issue),
		.raddr (rd_idx),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			head_q    <= '0;
			fill_q    <= '0;
			k_q       <= '0;
			len_q     <= '0;
			rd_vld_s1 <= 1'b0;
			dup_q     <= 1'b0;
			cnt_q     <= '0;
			limit_q   <= LIMIT_RESET;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid) begin
				limit_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q   <= ST_SCAN;
						k_q       <= '0;
						rd_vld_s1 <= 1'b0;
						dup_q     <= 1'b0;
						cnt_q     <= '0;
						if ((action == ACT_ADD) || (action == ACT_CNT)) begin
							len_q <= fill_q;
						end else if ((action == ACT_FWD) && (fill_q != '0)) begin
							len_q <= FW'(1);
						end else begin
							len_q <= '0;
						end
					end
				end
				ST_SCAN: begin
					rd_vld_s1 <= issue;
					if (issue) begin
						k_q <= k_q + FW'(1);
					end
					if (rd_vld_s1) begin
						if (hit_dup) begin
							dup_q <= 1'b1;
						end
						if (hit_cnt && (cnt_q != CNT_MAX)) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end
					if (!issue && !rd_vld_s1) begin
						state_q <= ST_ADJ;
					end
				end
				ST_ADJ: begin
					if ((act_q == ACT_ADD) && !dup_q) begin
						state_q <= ST_WR;
					end else begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
					if (!((act_q == ACT_ADD) && dup_q)) begin
						head_q <= HW'(adv_wrap);
						fill_q <= new_fill;
					end
				end
				ST_WR: begin
					fill_q  <= fill_q + FW'(1);
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q   <= action;
			src_q   <= src_addr[AW-1:0];
			dst_q   <= dst_addr[AW-1:0];
			stamp_q <= stamp;
			ws_q    <= window_start;
			we_q    <= window_end;
		end
		if (state_q == ST_ADJ) begin
			ok_q        <= 1'b0;
			out_src_q   <= '0;
			out_dst_q   <= '0;
			out_stamp_q <= '0;
			match_q     <= '0;
			if (act_q == ACT_FWD) begin
				if (fill_q != '0) begin
					ok_q        <= 1'b1;
					out_src_q   <= ADDR_W'(rd_src);
					out_dst_q   <= ADDR_W'(rd_dst);
					out_stamp_q <= rd_stamp;
				end
			end else if (act_q == ACT_CNT) begin
				match_q <= cnt_q;
			end
		end
		if (state_q == ST_WR) begin
			ok_q <= 1'b1;
		end
	end

	assign done        = done_q;
	assign ok          = ok_q;
	assign out_src     = out_src_q;
	assign out_dst     = out_dst_q;
	assign out_stamp   = out_stamp_q;
	assign match_count = match_q;

endmodule

[rtl/dfpb_mem.sv]
module dfpb_mem #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	parameter int IDX_W = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [IDX_W-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/dfpb_checker.sv]
module dfpb_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic                          ok,
	input logic [dfpb_pkg::ADDR_W-1:0]   out_src,
	input logic [dfpb_pkg::ADDR_W-1:0]   out_dst,
	input logic [dfpb_pkg::STAMP_W-1:0]  out_stamp,
	input logic [dfpb_pkg::CNT_W-1:0]    match_count
);
	import dfpb_pkg::*;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after command transfer");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_no_pkt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !ok |-> (out_src == '0) && (out_dst == '0) && (out_stamp == '0))
		else $error("packet fields set without a forwarded packet");

	a_cnt_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done && (match_count != '0) |-> !ok)
		else $error("count result together with ok");

endmodule

bind dedup_fifo_packet_buffer dfpb_checker u_dfpb_checker (.*);

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import dfpb_pkg::*;

	localparam logic [ACT_W-1:0] ACT_NOP = 2'd3;
	localparam int SLOTS        = DEPTH_DEF;
	localparam int IDLE_LIMIT   = 400;
	localparam int DRAIN_CYCLES = 24;
	localparam int PHASES       = 10;
	localparam int PHASE_ITEMS  = 70;
	localparam int MAX_PRINTS   = 60;
	localparam int RECENT_KEEP  = 32;

	typedef struct packed {
		logic [ACT_W-1:0]   act;
		logic [ADDR_W-1:0]  src;
		logic [ADDR_W-1:0]  dst;
		logic [STAMP_W-1:0] stmp;
		logic [STAMP_W-1:0] win_lo;
		logic [STAMP_W-1:0] win_hi;
	} cmd_t;

	typedef struct packed {
		logic               ok;
		logic [ADDR_W-1:0]  src;
		logic [ADDR_W-1:0]  dst;
		logic [STAMP_W-1:0] stmp;
		logic [CNT_W-1:0]   cnt;
	} reply_t;

	class packet_buffer_shadow;
		logic [ADDR_W-1:0]  pkt_src [SLOTS];
		logic [ADDR_W-1:0]  pkt_dst [SLOTS];
		logic [STAMP_W-1:0] pkt_stmp [SLOTS];
		int unsigned        oldest;
		int unsigned        held;
		logic [LIMIT_W-1:0] cap;
		reply_t             replies_due[$];
		int                 mismatch_cnt;

		function new();
			oldest = 0;
			held = 0;
			cap = LIMIT_RESET;
			mismatch_cnt = 0;
		endfunction

		function void set_cap(logic [LIMIT_W-1:0] v);
			cap = v;
		endfunction

		// zero acts as one, anything above the depth as the depth
		function int unsigned room();
			if (cap == 0) return 1;
			if (cap > SLOTS) return SLOTS;
			return cap;
		endfunction

		function void note_command(cmd_t c);
			reply_t      r;
			int unsigned k;
			int unsigned s;
			int unsigned n;
			bit          twin;
			r = '0;
			case (c.act)
			ACT_ADD: begin
				twin = 1'b0;
				for (k = 0; k < held; k++) begin
					s = (oldest + k) % SLOTS;
					if (pkt_src[s] == c.src && pkt_dst[s] == c.dst && pkt_stmp[s] == c.stmp)
						twin = 1'b1;
				end
				if (!twin) begin
					while (held >= room()) begin
						oldest = (oldest + 1) % SLOTS;
						held--;
					end
					s = (oldest + held) % SLOTS;
					pkt_src[s] = c.src;
					pkt_dst[s] = c.dst;
					pkt_stmp[s] = c.stmp;
					held++;
					r.ok = 1'b1;
				end
			end
			ACT_FWD: begin
				if (held != 0) begin
					r.ok = 1'b1;
					r.src = pkt_src[oldest];
					r.dst = pkt_dst[oldest];
					r.stmp = pkt_stmp[oldest];
					oldest = (oldest + 1) % SLOTS;
					held--;
				end
			end
			ACT_CNT: begin
				n = 0;
				for (k = 0; k < held; k++) begin
					s = (oldest + k) % SLOTS;
					if (pkt_dst[s] == c.dst && pkt_stmp[s] >= c.win_lo && pkt_stmp[s] <= c.win_hi)
						n++;
				end
				r.cnt = (n > CNT_MAX) ? CNT_MAX : n[CNT_W-1:0];
			end
			default: ;
			endcase
			replies_due.insert(replies_due.size(), r);
		endfunction

		task report(string msg);
			if (mismatch_cnt < MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
			mismatch_cnt++;
		endtask

		task check_field(string name, logic [STAMP_W-1:0] got, logic [STAMP_W-1:0] want);
			if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
		endtask

		task check_reply(reply_t got);
			reply_t want;
			if (replies_due.size() == 0) begin
				report($sformatf("result with nothing pending: ok=%0b src=%0h dst=%0h cnt=%0d",
					got.ok, got.src, got.dst, got.cnt));
				return;
			end
			want = replies_due.pop_front();
			check_field("ok", STAMP_W'(got.ok), STAMP_W'(want.ok));
			check_field("out_src", STAMP_W'(got.src), STAMP_W'(want.src));
			check_field("out_dst", STAMP_W'(got.dst), STAMP_W'(want.dst));
			check_field("out_stamp", got.stmp, want.stmp);
			check_field("match_count", STAMP_W'(got.cnt), STAMP_W'(want.cnt));
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic [ACT_W-1:0]    action = '0;
	logic [ADDR_W-1:0]   src_addr = '0;
	logic [ADDR_W-1:0]   dst_addr = '0;
	logic [STAMP_W-1:0]  stamp = '0;
	logic [STAMP_W-1:0]  window_start = '0;
	logic [STAMP_W-1:0]  window_end = '0;
	logic                cfg_valid = 1'b0;
	logic [LIMIT_W-1:0]  cfg_data = '0;
	logic                busy;
	logic                cfg_ready;
	logic                done;
	logic                ok;
	logic [ADDR_W-1:0]   out_src;
	logic [ADDR_W-1:0]   out_dst;
	logic [STAMP_W-1:0]  out_stamp;
	logic [CNT_W-1:0]    match_count;

	packet_buffer_shadow book;
	cmd_t                recent[$];

	always #4 clk = ~clk;

	dedup_fifo_packet_buffer i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.src_addr     (src_addr),
		.dst_addr     (dst_addr),
		.stamp        (stamp),
		.window_start (window_start),
		.window_end   (window_end),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.done         (done),
		.ok           (ok),
		.out_src      (out_src),
		.out_dst      (out_dst),
		.out_stamp    (out_stamp),
		.match_count  (match_count)
	);

	always @(posedge clk) begin
		if (arst_n && done) begin
			book.check_reply({ok, out_src, out_dst, out_stamp, match_count});
		end
	end

	function automatic cmd_t order(logic [ACT_W-1:0] a, logic [ADDR_W-1:0] s,
			logic [ADDR_W-1:0] d, logic [STAMP_W-1:0] t, logic [STAMP_W-1:0] lo,
			logic [STAMP_W-1:0] hi);
		return {a, s, d, t, lo, hi};
	endfunction

	function automatic logic [ADDR_W-1:0] pick_addr();
		case ($urandom_range(0, 9))
		0: return 16'h0000;
		1: return 16'hFFFF;
		2: return 16'h1234;
		3: return 16'hA5A5;
		4: return 16'h5A5A;
		5: return 16'h0001;
		default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [STAMP_W-1:0] pick_stamp();
		case ($urandom_range(0, 9))
		0: return 32'h0000_0000;
		1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
		2, 3, 4, 5: return $urandom_range(0, 64);
		default: return $urandom;
		endcase
	endfunction

	function automatic cmd_t make_cmd(int unsigned add_pct);
		cmd_t        c;
		cmd_t        seen;
		int unsigned roll;
		c = {ACT_FWD, 16'($urandom), 16'($urandom), 32'($urandom), 32'($urandom),
			32'($urandom)};
		seen = c;
		if (recent.size() != 0) seen = recent[$urandom_range(0, recent.size() - 1)];
		roll = $urandom_range(0, 99);
		if (roll < 3) begin
			c.act = ACT_NOP;
		end else if (roll < 3 + add_pct) begin
			c.act = ACT_ADD;
			c.src = pick_addr();
			c.dst = pick_addr();
			c.stmp = pick_stamp();
			if (recent.size() != 0 && $urandom_range(0, 2) == 0) begin
				c.src = seen.src;
				c.dst = seen.dst;
				c.stmp = seen.stmp;
				// near miss: one bit off in one field, or an exact repeat
				case ($urandom_range(0, 5))
				0: c.src ^= 16'h1 << $urandom_range(0, 15);
				1: c.dst ^= 16'h1 << $urandom_range(0, 15);
				2: c.stmp ^= 32'h1 << $urandom_range(0, 31);
				default: ;
				endcase
			end
			recent.insert(recent.size(), c);
			if (recent.size() > RECENT_KEEP) void'(recent.pop_front());
		end else if (roll < 3 + add_pct + (97 - add_pct) / 2) begin
			c.act = ACT_CNT;
			if ($urandom_range(0, 3) != 0) c.dst = seen.dst;
			else c.dst = pick_addr();
			case ($urandom_range(0, 9))
			0: begin
				c.win_lo = 32'h0000_0000;
				c.win_hi = 32'hFFFF_FFFF;
			end
			1: begin
				c.win_lo = $urandom_range(32'h8000_0000, 32'hFFFF_FFFF);
				c.win_hi = c.win_lo - $urandom_range(1, 1000);
			end
			2, 3, 4, 5, 6: begin
				c.win_lo = seen.stmp - $urandom_range(0, 20);
				c.win_hi = seen.stmp + $urandom_range(0, 20);
			end
			default: ;
			endcase
		end
		return c;
	endfunction

	task automatic issue(input cmd_t c, input bit may_pause);
		start <= 1'b1;
		action <= c.act;
		src_addr <= c.src;
		dst_addr <= c.dst;
		stamp <= c.stmp;
		window_start <= c.win_lo;
		window_end <= c.win_hi;
		do @(posedge clk); while (busy);
		book.note_command(c);
		if (may_pause && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	task automatic set_limit(input logic [LIMIT_W-1:0] v);
		start <= 1'b0;
		while (book.replies_due.size() != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		book.set_cap(v);
		cfg_valid <= 1'b0;
	endtask

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done || (cfg_valid && cfg_ready)) quiet = 0;
			else quiet++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin : stimulus
		logic [LIMIT_W-1:0] caps [PHASES];
		int unsigned        phase;
		int unsigned        n;
		int unsigned        add_pct;
		bit                 pausing;
		book = new();
		caps = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd17, 5'd2, 5'($urandom), 5'd16, 5'd3,
			5'($urandom)};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(order(ACT_FWD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0), 1'b1);
		issue(order(ACT_CNT, 16'h0, 16'hFFFF, 32'h0, 32'h0, 32'hFFFF_FFFF), 1'b1);
		issue(order(ACT_NOP, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF), 1'b1);
		issue(order(ACT_ADD, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0), 1'b1);
		issue(order(ACT_ADD, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'h0, 32'h0), 1'b1);
		issue(order(ACT_ADD, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0), 1'b1);
		issue(order(ACT_ADD, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'h0, 32'h0), 1'b1);
		issue(order(ACT_ADD, 16'h0000, 16'hFFFF, 32'h0, 32'h0, 32'h0), 1'b1);
		issue(order(ACT_CNT, 16'h0, 16'hFFFF, 32'h0, 32'h0, 32'hFFFF_FFFF), 1'b1);
		issue(order(ACT_CNT, 16'h0, 16'h0000, 32'h0, 32'h0, 32'h0), 1'b1);
		issue(order(ACT_CNT, 16'h0, 16'hFFFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b1);
		// start above end: nothing can match
		issue(order(ACT_CNT, 16'h0, 16'hFFFF, 32'h0, 32'hFFFF_FFFF, 32'h0), 1'b1);
		issue(order(ACT_NOP, 16'h1, 16'h2, 32'h3, 32'h0, 32'hFFFF_FFFF), 1'b1);
		issue(order(ACT_FWD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0), 1'b1);
		issue(order(ACT_ADD, 16'h0001, 16'h0002, 32'd10, 32'h0, 32'h0), 1'b1);
		issue(order(ACT_ADD, 16'h0001, 16'h0002, 32'd11, 32'h0, 32'h0), 1'b1);
		issue(order(ACT_ADD, 16'h0001, 16'h0002, 32'd12, 32'h0, 32'h0), 1'b1);
		// limit drops below the fill: the limit trims no entries until the next add
		set_limit(5'd2);
		issue(order(ACT_CNT, 16'h0, 16'h0002, 32'h0, 32'd10, 32'd12), 1'b1);
		issue(order(ACT_FWD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0), 1'b1);
		issue(order(ACT_ADD, 16'h0003, 16'h0004, 32'd5, 32'h0, 32'h0), 1'b1);
		issue(order(ACT_CNT, 16'h0, 16'h0002, 32'h0, 32'h0, 32'hFFFF_FFFF), 1'b1);
		set_limit(5'd0);
		issue(order(ACT_ADD, 16'h0005, 16'h0006, 32'd7, 32'h0, 32'h0), 1'b1);
		issue(order(ACT_ADD, 16'h0005, 16'h0006, 32'd8, 32'h0, 32'h0), 1'b1);
		issue(order(ACT_FWD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0), 1'b1);
		issue(order(ACT_FWD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0), 1'b1);

		for (phase = 0; phase < PHASES; phase++) begin
			set_limit(caps[phase]);
			add_pct = $urandom_range(35, 70);
			pausing = (phase != PHASES - 1) && (phase % 3 != 2);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				issue(make_cmd(add_pct), pausing);
			end
		end

		start <= 1'b0;
		while (book.replies_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (book.mismatch_cnt == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/dfpb_pkg.sv
rtl/dfpb_mem.sv
rtl/dedup_fifo_packet_buffer.sv
rtl/dfpb_checker.sv
tb/sv/tb_top.sv
